### rtl/core/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator package
// Shared sizes, codes and types of the allocator core.
// ----------------------------------------------------------------------------
`default_nettype none

package fpfa_pkg;

   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;

   localparam int INDEX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int COUNT_BITS = $clog2(NUM_BLOCKS + 1);
   localparam int REQ_BITS   = 16;
   localparam int CMP_BITS   = (SIZE_BITS > REQ_BITS) ? SIZE_BITS : REQ_BITS;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_REQUEST = 2'd1;
   localparam logic [1:0] KIND_ROUND   = 2'd2;

   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   typedef logic [SIZE_BITS-1:0]  size_type;
   typedef logic [INDEX_BITS-1:0] index_type;

   // One entry under examination by the fit unit.
   typedef struct packed {
      logic     valid;
      logic     free;
      size_type size;
   } cand_type;

   // Running choice of the scan.
   typedef struct packed {
      logic      have;
      size_type  size;
      index_type index;
   } best_type;

endpackage

`default_nettype wire

### rtl/core/fpfa_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel that carries load, request and new-round items.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpfa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [3:0]  block_index;
   logic [15:0] size_value;

   modport source (output valid, kind, block_index, size_value, input ready);
   modport sink   (input valid, kind, block_index, size_value, output ready);
endinterface

`default_nettype wire

### rtl/core/fpfa_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel that carries the outcome of one allocation request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpfa_rsp_if;
   logic       valid;
   logic       ready;
   logic       granted;
   logic [3:0] granted_block;

   modport source (output valid, granted, granted_block, input ready);
   modport sink   (input valid, granted, granted_block, output ready);
endinterface

`default_nettype wire

### rtl/core/fpfa_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/fpfa_fit_unit.sv
// ----------------------------------------------------------------------------
// Allocator fit unit
// Shared compare unit that decides whether one entry replaces the current choice.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_fit_unit (
   input  wire fpfa_pkg::cand_type         cand,
   input  wire fpfa_pkg::best_type         best,
   input  wire logic [1:0]                 policy,
   input  wire logic [fpfa_pkg::REQ_BITS-1:0] want,
   output      logic                       take
);
   import fpfa_pkg::*;

   logic fits;
   logic smaller;
   logic larger;

   always_comb begin
      fits    = cand.valid && cand.free && (CMP_BITS'(cand.size) >= CMP_BITS'(want));
      smaller = cand.size < best.size;
      larger  = cand.size > best.size;
      take    = 1'b0;
      if (fits) begin
         if (!best.have) begin
            take = 1'b1;
         end else begin
            // Strict compares keep ties on the lower index.
            case (policy)
               POLICY_BEST:  take = smaller;
               POLICY_WORST: take = larger;
               default:      take = 1'b0;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/fixed_partition_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator core
// Grants blocks from a table of fixed partitions by first, best or worst fit.
// ----------------------------------------------------------------------------
// A load or new-round transfer updates the table and gives no response.
// A request walks the size table one entry per cycle through a single RAM read
// port and one shared compare unit, and the core is not ready for another item
// until the scan ends and its response is registered; the response is held in an
// output register until it is taken.
// The fit policy register may be written at any cycle while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_fit_allocator_core (
   input  wire logic       clock,
   input  wire logic       reset,
   fpfa_req_if.sink        req_if,
   fpfa_rsp_if.source      rsp_if,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data
);
   import fpfa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_OUTPUT = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              policy_ff;
   logic [NUM_BLOCKS-1:0]   loaded_ff, loaded_in;
   logic [NUM_BLOCKS-1:0]   free_ff, free_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    eval_valid_ff, eval_valid_in;
   index_type               eval_index_ff, eval_index_in;
   logic [REQ_BITS-1:0]     want_ff, want_in;
   best_type                best_ff, best_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_granted_ff, rsp_granted_in;
   logic [3:0]              rsp_block_ff, rsp_block_in;

   logic       req_xfer;
   logic       rsp_xfer;
   logic       load_hit;
   logic       ram_wr_en;
   logic       issue;
   size_type   rd_size;
   cand_type   cand;
   logic       take;
   index_type  load_index;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign rsp_xfer     = rsp_if.valid && rsp_if.ready;
   assign load_hit     = 32'(req_if.block_index) < NUM_BLOCKS;
   assign load_index   = INDEX_BITS'(req_if.block_index);
   assign ram_wr_en    = req_xfer && (req_if.kind == KIND_LOAD) && load_hit;
   assign issue        = (state_ff == ST_SCAN) && (32'(count_ff) < NUM_BLOCKS);

   fpfa_ram #(
      .WIDTH(SIZE_BITS),
      .DEPTH(NUM_BLOCKS)
   ) u_size_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(load_index),
      .wr_data(SIZE_BITS'(req_if.size_value)),
      .rd_en  (issue),
      .rd_addr(count_ff[INDEX_BITS-1:0]),
      .rd_data(rd_size)
   );

   always_comb begin
      cand.valid = eval_valid_ff;
      cand.free  = free_ff[eval_index_ff];
      cand.size  = rd_size;
   end

   fpfa_fit_unit u_fit (
      .cand  (cand),
      .best  (best_ff),
      .policy(policy_ff),
      .want  (want_ff),
      .take  (take)
   );

   always_comb begin
      state_in       = state_ff;
      loaded_in      = loaded_ff;
      free_in        = free_ff;
      count_in       = count_ff;
      eval_valid_in  = 1'b0;
      eval_index_in  = eval_index_ff;
      want_in        = want_ff;
      best_in        = best_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_xfer;
      rsp_granted_in = rsp_granted_ff;
      rsp_block_in   = rsp_block_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_if.kind)
                  KIND_LOAD: begin
                     if (load_hit) begin
                        loaded_in[load_index] = 1'b1;
                        free_in[load_index]   = 1'b1;
                     end
                  end
                  KIND_ROUND: begin
                     free_in = loaded_ff;
                  end
                  KIND_REQUEST: begin
                     count_in     = '0;
                     want_in      = req_if.size_value;
                     best_in.have = 1'b0;
                     state_in     = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Read of entry k is issued in the cycle before its compare.
            if (issue) begin
               count_in      = count_ff + COUNT_BITS'(1);
               eval_valid_in = 1'b1;
               eval_index_in = count_ff[INDEX_BITS-1:0];
            end
            if (take) begin
               best_in.have  = 1'b1;
               best_in.size  = rd_size;
               best_in.index = eval_index_ff;
            end
            if (!issue && eval_valid_ff) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_xfer) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = best_ff.have;
               rsp_block_in   = best_ff.have ? 4'(best_ff.index) : 4'd0;
               if (best_ff.have) begin
                  free_in[best_ff.index] = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         policy_ff     <= POLICY_BEST;
         loaded_ff     <= '0;
         free_ff       <= '0;
         eval_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         loaded_ff     <= loaded_in;
         free_ff       <= free_in;
         eval_valid_ff <= eval_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff       <= count_in;
      eval_index_ff  <= eval_index_in;
      want_ff        <= want_in;
      best_ff        <= best_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_block_ff   <= rsp_block_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.granted       = rsp_granted_ff;
   assign rsp_if.granted_block = rsp_block_ff;

endmodule

`default_nettype wire

### tb/fixed_partition_fit_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator core testbench
// Loads the partition table and sends allocation requests and new-round items
// under each fit policy. Gaps and stalls are drawn at random on both channels.
// Every granted or refused response is checked against a cycle-free predictor
// of the table, in order and field by field.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_core_tb;
   import fpfa_pkg::*;

   localparam logic [1:0] KIND_UNUSED   = 2'd3;
   localparam logic [1:0] POLICY_UNUSED = 2'd3;
   localparam int NO_PICK       = -1;
   localparam int MAX_REPORTS   = 10;
   localparam int SETTLE_CYCLES = NUM_BLOCKS + 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 255;

   typedef struct packed {
      logic [1:0] kind;
      index_type  block_index;
      size_type   size_value;
   } alloc_item_type;

   typedef struct packed {
      logic      granted;
      index_type block;
   } grant_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;

   fpfa_req_if req_bus ();
   fpfa_rsp_if rsp_bus ();

   fixed_partition_fit_allocator_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Items waiting for the driver, and grants waiting for their response.
   alloc_item_type pending_items[$];
   grant_type      grant_queue[$];

   // Predicted table contents and policy.
   size_type              part_size[NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] part_loaded;
   logic [NUM_BLOCKS-1:0] part_free;
   logic [1:0]            policy_now;

   // Sizes as the stimulus generator last wrote them, used to aim requests.
   size_type shadow_size[NUM_BLOCKS];

   logic req_took;
   logic rsp_took;
   int   req_gap;
   int   req_calm;
   int   rsp_stall;
   int   rsp_calm;
   int   idle_cycles;
   int   failures;

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = ~clock;
   end

   // Mostly returns 0 to 8, with occasional runs that return 0 and do not wait at all.
   function automatic int draw_wait(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // Index of the block the policy selects, or NO_PICK when nothing fits.
   function automatic int choose_block(input size_type want);
      int pick;
      pick = NO_PICK;
      for (int j = 0; j < NUM_BLOCKS; j++) begin
         if (part_free[j] && part_size[j] >= want) begin
            if (pick == NO_PICK) begin
               pick = j;
               if (policy_now != POLICY_BEST && policy_now != POLICY_WORST) break;
            end else if (policy_now == POLICY_BEST && part_size[j] < part_size[pick]) begin
               pick = j;
            end else if (policy_now == POLICY_WORST && part_size[j] > part_size[pick]) begin
               pick = j;
            end
         end
      end
      return pick;
   endfunction

   task automatic track_item(input alloc_item_type item);
      int        pick;
      grant_type grant;
      case (item.kind)
         KIND_LOAD: begin
            part_size[item.block_index]   = item.size_value;
            part_loaded[item.block_index] = 1'b1;
            part_free[item.block_index]   = 1'b1;
         end
         KIND_ROUND: begin
            part_free = part_loaded;
         end
         KIND_REQUEST: begin
            pick = choose_block(item.size_value);
            grant.granted = (pick != NO_PICK);
            grant.block   = '0;
            if (grant.granted) begin
               grant.block     = index_type'(pick);
               part_free[pick] = 1'b0;
            end
            grant_queue.push_back(grant);
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", what);
   endtask

   task automatic push_item(input logic [1:0] kind, input index_type idx, input size_type size);
      alloc_item_type item;
      item.kind        = kind;
      item.block_index = idx;
      item.size_value  = size;
      if (kind == KIND_LOAD) shadow_size[idx] = size;
      pending_items.push_back(item);
   endtask

   function automatic size_type random_size(input int scope);
      case (scope)
         0:       return size_type'($urandom_range(0, 15));
         1:       return size_type'($urandom_range(0, 1023));
         2:       return size_type'($urandom_range(0, 65535));
         default: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return size_type'(1);
               2:       return {SIZE_BITS{1'b1}} - 1'b1;
               default: return {SIZE_BITS{1'b1}};
            endcase
         end
      endcase
   endfunction

   // Requests aim at sizes in the table, just around them, at the extremes, or at random.
   function automatic size_type request_size(input int scope);
      size_type near;
      near = shadow_size[$urandom_range(0, NUM_BLOCKS - 1)];
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return near;
         4:          return (near == {SIZE_BITS{1'b1}}) ? near : near + 1'b1;
         5:          return (near == '0) ? near : near - 1'b1;
         6:          return '0;
         7:          return {SIZE_BITS{1'b1}};
         default:    return random_size(scope);
      endcase
   endfunction

   // Most of a phase is made of rounds: a few reloads, a new round, then requests
   // until the table is often exhausted. The rest is items of random kind.
   task automatic queue_random_phase(input int target);
      int         added;
      int         scope;
      int         loads;
      int         asks;
      logic [1:0] kind;
      added = 0;
      while (added < target) begin
         scope = $urandom_range(0, 3);
         if ($urandom_range(0, 9) < 8) begin
            loads = $urandom_range(0, 5);
            asks  = $urandom_range(2, 20);
            repeat (loads) begin
               push_item(KIND_LOAD, index_type'($urandom_range(0, 15)), random_size(scope));
            end
            push_item(KIND_ROUND, index_type'($urandom_range(0, 15)),
                      size_type'($urandom_range(0, 65535)));
            repeat (asks) begin
               push_item(KIND_REQUEST, index_type'($urandom_range(0, 15)), request_size(scope));
            end
            added += loads + 1 + asks;
         end else begin
            repeat ($urandom_range(1, 6)) begin
               kind = 2'($urandom_range(0, 3));
               push_item(kind, index_type'($urandom_range(0, 15)),
                         size_type'($urandom_range(0, 65535)));
               if (kind != KIND_UNUSED) added++;
            end
         end
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_bus.valid || grant_queue.size() != 0);
   endtask

   task automatic write_policy(input logic [1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Request driver.
   always @(negedge clock) begin
      alloc_item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_took) begin
         if (req_took) req_gap = draw_wait(req_calm);
         if (req_gap > 0 || pending_items.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_bus.valid <= 1'b0;
         end else begin
            next_item = pending_items.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.kind        <= next_item.kind;
            req_bus.block_index <= next_item.block_index;
            req_bus.size_value  <= next_item.size_value;
         end
      end
   end

   // Response receiver: after each transfer it holds ready low for a drawn
   // number of cycles in which a response is offered.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_took) rsp_stall = draw_wait(rsp_calm);
         rsp_bus.ready <= (rsp_stall == 0);
         if (rsp_stall > 0 && rsp_bus.valid) rsp_stall--;
      end
   end

   // Monitor: follows configuration writes and input transfers in the predictor
   // and checks each response transfer against the oldest grant.
   always @(posedge clock) begin
      alloc_item_type seen;
      grant_type      want;
      req_took <= req_bus.valid && req_bus.ready;
      rsp_took <= rsp_bus.valid && rsp_bus.ready;
      if (reset) begin
         part_loaded = '0;
         part_free   = '0;
         policy_now  = POLICY_BEST;
         grant_queue.delete();
         idle_cycles = 0;
      end else begin
         if ($isunknown(rsp_bus.valid)) report_failure("response valid is unknown");
         if (csr_wr_en) policy_now = csr_wr_data;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (grant_queue.size() == 0) begin
               report_failure($sformatf("unexpected response: granted=%0d block=%0d",
                                        rsp_bus.granted, rsp_bus.granted_block));
            end else begin
               want = grant_queue.pop_front();
               if (rsp_bus.granted !== want.granted || rsp_bus.granted_block !== want.block)
                  report_failure($sformatf(
                     "response mismatch: expected granted=%0d block=%0d, got granted=%0d block=%0d",
                     want.granted, want.block, rsp_bus.granted, rsp_bus.granted_block));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.kind        = req_bus.kind;
            seen.block_index = req_bus.block_index;
            seen.size_value  = req_bus.size_value;
            track_item(seen);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [1:0] phase_policy[6];
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.kind        = '0;
      req_bus.block_index = '0;
      req_bus.size_value  = '0;
      rsp_bus.ready       = 1'b0;
      req_gap     = 0;
      req_calm    = 0;
      rsp_stall   = 0;
      rsp_calm    = 0;
      idle_cycles = 0;
      failures    = 0;
      phase_policy = '{POLICY_FIRST, POLICY_WORST, POLICY_UNUSED,
                       POLICY_BEST, POLICY_WORST, POLICY_FIRST};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset policy (best fit). Every block is loaded
      // before the first request, with ties, a zero size and the largest size.
      push_item(KIND_LOAD, 4'd0,  16'd300);
      push_item(KIND_LOAD, 4'd1,  16'd50);
      push_item(KIND_LOAD, 4'd2,  16'd200);
      push_item(KIND_LOAD, 4'd3,  16'd50);
      push_item(KIND_LOAD, 4'd4,  16'hFFFF);
      push_item(KIND_LOAD, 4'd5,  16'd0);
      push_item(KIND_LOAD, 4'd6,  16'd1000);
      push_item(KIND_LOAD, 4'd7,  16'd200);
      push_item(KIND_LOAD, 4'd8,  16'd7);
      push_item(KIND_LOAD, 4'd9,  16'hFFFE);
      push_item(KIND_LOAD, 4'd10, 16'd120);
      push_item(KIND_LOAD, 4'd11, 16'd50);
      push_item(KIND_LOAD, 4'd12, 16'd4096);
      push_item(KIND_LOAD, 4'd13, 16'd1);
      push_item(KIND_LOAD, 4'd14, 16'd800);
      push_item(KIND_LOAD, 4'd15, 16'h8000);
      push_item(KIND_REQUEST, 4'd0, 16'd0);
      push_item(KIND_REQUEST, 4'd15, 16'hFFFF);
      push_item(KIND_REQUEST, 4'd0, 16'hFFFF);
      push_item(KIND_UNUSED, 4'd15, 16'hFFFF);
      push_item(KIND_REQUEST, 4'd0, 16'd50);
      // Reloading a block that is in use makes it free again.
      push_item(KIND_LOAD, 4'd1, 16'd50);
      push_item(KIND_REQUEST, 4'd0, 16'd50);
      push_item(KIND_ROUND, 4'd0, 16'd0);
      push_item(KIND_REQUEST, 4'd0, 16'd40000);

      // The sender stops until the core is empty before each policy change.
      foreach (phase_policy[p]) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_policy(phase_policy[p]);
         queue_random_phase(PHASE_ITEMS);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### filelist.f
rtl/core/fpfa_pkg.sv
rtl/core/fpfa_req_if.sv
rtl/core/fpfa_rsp_if.sv
rtl/core/fpfa_ram.sv
rtl/core/fpfa_fit_unit.sv
rtl/core/fixed_partition_fit_allocator_core.sv
tb/fixed_partition_fit_allocator_core_tb.sv
